// File: rtl/otfd_pkg.sv
// Shared types and constants for the OOK thermometer frame decoder.
// No dependencies; every other file in the project imports this package.
package otfd_pkg;

  localparam int DurBits    = 16;
  localparam int CodeBits   = 24;
  localparam int TempBits   = 12;
  localparam int IdxBits    = 6;
  localparam int PulseCount = 48;
  localparam int CfgAddrW   = 5;
  localparam int CfgDataW   = 32;
  localparam int CfgIdxW    = 3;

  localparam logic [7:0]    SyncId      = 8'hFF;
  localparam logic [3:0]    BattGoodNib = 4'h0;
  localparam logic [IdxBits-1:0] LastPulse = IdxBits'(PulseCount - 1);

  typedef enum logic [1:0] {
    ST_NEW    = 2'd0,
    ST_REPEAT = 2'd1,
    ST_SYNC   = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_MIN     = 3'd0,
    REG_SYNC_MAX     = 3'd1,
    REG_HIGH_MAX     = 3'd2,
    REG_ZERO_LOW_MIN = 3'd3,
    REG_ZERO_LOW_MAX = 3'd4,
    REG_ONE_LOW_MIN  = 3'd5
  } cfg_idx_t;

  localparam logic [DurBits-1:0] SyncMinRst    = 16'd7781;
  localparam logic [DurBits-1:0] SyncMaxRst    = 16'd8059;
  localparam logic [DurBits-1:0] HighMaxRst    = 16'd999;
  localparam logic [DurBits-1:0] ZeroLowMinRst = 16'd1001;
  localparam logic [DurBits-1:0] ZeroLowMaxRst = 16'd2999;
  localparam logic [DurBits-1:0] OneLowMinRst  = 16'd3001;

endpackage

// File: rtl/otfd_if.sv
// Valid/ready channel interfaces for the pulse input and the decoded result.
// Depends on otfd_pkg for field widths and the status type.
interface otfd_in_if;
  import otfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [DurBits-1:0] duration;
  logic               frame_start;

  modport source (output valid, duration, frame_start, input ready);
  modport sink   (input valid, duration, frame_start, output ready);
endinterface

interface otfd_out_if;
  import otfd_pkg::*;
  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic [7:0]                 sensor_id;
  logic signed [TempBits-1:0] temp_tenths;
  logic                       battery_ok;
  logic [CodeBits-1:0]        raw_code;

  modport source (output valid, status, sensor_id, temp_tenths, battery_ok, raw_code,
                  input ready);
  modport sink   (input valid, status, sensor_id, temp_tenths, battery_ok, raw_code,
                  output ready);
endinterface

// File: rtl/ook_thermometer_frame_decoder_core.sv
// Top level of the OOK thermometer frame decoder: input register, decode logic,
// result register and the APB-style threshold registers. Uses otfd_pkg and otfd_if.
//
// Each duration word is captured in an input register and decoded from that register
// by a handful of 16-bit compares, a shift of the 24-bit code and, on the last
// pulse of a frame, a multiply-by-ten built from two shifts and adds. The block takes
// one word per clock while the result register is free or being taken; a result word
// sits in the output register until it is taken, and the input register keeps
// accepting as long as the result side moves. Only a failed sync window check,
// malformed pulses and the 48th pulse of a frame produce result words.
module ook_thermometer_frame_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  otfd_in_if.sink                       in_ch,
  otfd_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [otfd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [otfd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [otfd_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import otfd_pkg::*;

  // Threshold registers
  logic [DurBits-1:0] sync_min_r, sync_max_r, high_max_r;
  logic [DurBits-1:0] zero_low_min_r, zero_low_max_r, one_low_min_r;
  logic [CfgIdxW-1:0] cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CfgIdxW+1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r     <= SyncMinRst;
      sync_max_r     <= SyncMaxRst;
      high_max_r     <= HighMaxRst;
      zero_low_min_r <= ZeroLowMinRst;
      zero_low_max_r <= ZeroLowMaxRst;
      one_low_min_r  <= OneLowMinRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC_MIN:     sync_min_r     <= cfg_pwdata[DurBits-1:0];
        REG_SYNC_MAX:     sync_max_r     <= cfg_pwdata[DurBits-1:0];
        REG_HIGH_MAX:     high_max_r     <= cfg_pwdata[DurBits-1:0];
        REG_ZERO_LOW_MIN: zero_low_min_r <= cfg_pwdata[DurBits-1:0];
        REG_ZERO_LOW_MAX: zero_low_max_r <= cfg_pwdata[DurBits-1:0];
        REG_ONE_LOW_MIN:  one_low_min_r  <= cfg_pwdata[DurBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_SYNC_MIN:     cfg_prdata = CfgDataW'(sync_min_r);
      REG_SYNC_MAX:     cfg_prdata = CfgDataW'(sync_max_r);
      REG_HIGH_MAX:     cfg_prdata = CfgDataW'(high_max_r);
      REG_ZERO_LOW_MIN: cfg_prdata = CfgDataW'(zero_low_min_r);
      REG_ZERO_LOW_MAX: cfg_prdata = CfgDataW'(zero_low_max_r);
      REG_ONE_LOW_MIN:  cfg_prdata = CfgDataW'(one_low_min_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Input register
  logic               s0_valid_r;
  logic [DurBits-1:0] s0_dur_r;
  logic               s0_start_r;
  logic               s0_adv;

  // Output register
  logic                       out_valid_r;
  status_t                    out_status_r;
  logic [7:0]                 out_id_r;
  logic signed [TempBits-1:0] out_temp_r;
  logic                       out_batt_r;
  logic [CodeBits-1:0]        out_code_r;

  assign s0_adv      = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_dur_r   <= in_ch.duration;
      s0_start_r <= in_ch.frame_start;
    end
  end

  // Frame state
  logic [IdxBits-1:0]         pulse_idx_r, pulse_idx_nxt;
  logic                       active_r, active_nxt;
  logic                       high_short_r, high_short_nxt;
  logic [CodeBits-1:0]        code_r, code_nxt;
  logic signed [TempBits-1:0] last_temp_r, last_temp_nxt;
  logic                       last_valid_r, last_valid_nxt;

  // Decode results
  logic                       res_valid;
  status_t                    res_status;
  logic [7:0]                 res_id;
  logic signed [TempBits-1:0] res_temp;
  logic                       res_batt;
  logic [CodeBits-1:0]        res_code;

  // Field split of the code as it stands after this pulse's bit shifts in
  logic [CodeBits-1:0]        code_shifted;
  logic                       bit_val;
  logic                       zero_hit, one_hit;
  logic [6:0]                 deg_int;
  logic [TempBits-2:0]        mag;
  logic signed [TempBits-1:0] temp_val;

  assign zero_hit     = (s0_dur_r >= zero_low_min_r) && (s0_dur_r <= zero_low_max_r);
  assign one_hit      = (s0_dur_r >= one_low_min_r);
  assign bit_val      = !zero_hit;
  assign code_shifted = {code_r[CodeBits-2:0], bit_val};
  assign deg_int      = code_shifted[14:8];
  assign mag          = {1'b0, deg_int, 3'b000} + {3'b000, deg_int, 1'b0}
                      + {7'd0, code_shifted[3:0]};
  assign temp_val     = code_shifted[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_comb begin
    pulse_idx_nxt  = pulse_idx_r;
    active_nxt     = active_r;
    high_short_nxt = high_short_r;
    code_nxt       = code_r;
    last_temp_nxt  = last_temp_r;
    last_valid_nxt = last_valid_r;
    res_valid      = 1'b0;
    res_status     = ST_BAD;
    res_id         = '0;
    res_temp       = '0;
    res_batt       = 1'b0;
    res_code       = '0;

    if (s0_start_r) begin
      pulse_idx_nxt  = '0;
      high_short_nxt = 1'b0;
      code_nxt       = '0;
      if ((s0_dur_r >= sync_min_r) && (s0_dur_r <= sync_max_r)) begin
        active_nxt = 1'b1;
      end else begin
        active_nxt = 1'b0;
        res_valid  = 1'b1;
      end
    end else if (active_r) begin
      if (!pulse_idx_r[0]) begin
        if (s0_dur_r > high_max_r) begin
          active_nxt     = 1'b0;
          pulse_idx_nxt  = '0;
          high_short_nxt = 1'b0;
          res_valid      = 1'b1;
        end else begin
          high_short_nxt = 1'b1;
          pulse_idx_nxt  = pulse_idx_r + 1'b1;
        end
      end else if (!high_short_r || !(zero_hit || one_hit)) begin
        active_nxt     = 1'b0;
        pulse_idx_nxt  = '0;
        high_short_nxt = 1'b0;
        res_valid      = 1'b1;
      end else begin
        code_nxt       = code_shifted;
        high_short_nxt = 1'b0;
        pulse_idx_nxt  = pulse_idx_r + 1'b1;
        if (pulse_idx_r == LastPulse) begin
          // Last low of the frame: report the completed code.
          active_nxt    = 1'b0;
          pulse_idx_nxt = '0;
          res_valid     = 1'b1;
          res_id        = code_shifted[23:16];
          res_code      = code_shifted;
          if (code_shifted[23:16] == SyncId) begin
            res_status = ST_SYNC;
          end else begin
            res_temp = temp_val;
            res_batt = (code_shifted[7:4] == BattGoodNib);
            if (last_valid_r && (temp_val == last_temp_r)) begin
              res_status = ST_REPEAT;
            end else begin
              res_status     = ST_NEW;
              last_temp_nxt  = temp_val;
              last_valid_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_idx_r  <= '0;
      active_r     <= 1'b0;
      high_short_r <= 1'b0;
      code_r       <= '0;
      last_temp_r  <= '0;
      last_valid_r <= 1'b0;
    end else if (s0_adv) begin
      pulse_idx_r  <= pulse_idx_nxt;
      active_r     <= active_nxt;
      high_short_r <= high_short_nxt;
      code_r       <= code_nxt;
      last_temp_r  <= last_temp_nxt;
      last_valid_r <= last_valid_nxt;
    end
  end

  // The result register loads whenever a word leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && res_valid) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_temp_r   <= res_temp;
      out_batt_r   <= res_batt;
      out_code_r   <= res_code;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.sensor_id   = out_id_r;
  assign out_ch.temp_tenths = out_temp_r;
  assign out_ch.battery_ok  = out_batt_r;
  assign out_ch.raw_code    = out_code_r;

endmodule

// File: bench/tb.sv
// Self-checking bench for ook_thermometer_frame_decoder_core: drives pulse words and
// threshold registers, predicts every decoded reading and checks each result word.
// Depends on otfd_pkg, otfd_in_if/otfd_out_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import otfd_pkg::*;

  localparam int NumRegs    = 6;
  localparam int CycleLimit = 1_000_000;
  localparam int DurMax     = (1 << DurBits) - 1;

  typedef struct packed {
    status_t                    status;
    logic [7:0]                 sensor_id;
    logic signed [TempBits-1:0] temp_tenths;
    logic                       battery_ok;
    logic [CodeBits-1:0]        raw_code;
  } reading_t;

  typedef enum {FLAW_NONE, FLAW_HIGH, FLAW_LOW, FLAW_CUT, FLAW_SYNC} flaw_t;
  typedef enum {SET_WIDE, SET_TIGHT, SET_ORDERED, SET_ANY, SET_RESET} setting_t;

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  otfd_in_if  in_ch();
  otfd_out_if out_ch();

  ook_thermometer_frame_decoder_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Thresholds and decoder state as the bench believes them to be.
  logic [DurBits-1:0]  thr [NumRegs];
  logic [IdxBits-1:0]  pulse_idx;
  bit                  in_frame;
  bit                  high_ok;
  logic [CodeBits-1:0] code_sr;
  int                  last_temp;
  bit                  last_temp_seen;

  reading_t pending_readings[$];
  reading_t want;
  int       mismatches;
  int       fed_words;
  int       hold_off;
  bit       calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic reading_t bad_reading();
    reading_t r;
    r.status      = ST_BAD;
    r.sensor_id   = '0;
    r.temp_tenths = '0;
    r.battery_ok  = 1'b0;
    r.raw_code    = '0;
    return r;
  endfunction

  // Decoder prediction for one accepted word.
  task automatic decode_pulse(input logic [DurBits-1:0] dur, input logic start,
                              output bit emit, output reading_t r);
    int mag;
    int t;
    bit bitv;
    bit ok;
    r    = bad_reading();
    emit = 1'b0;
    ok   = 1'b1;
    if (start) begin
      pulse_idx = '0;
      high_ok   = 1'b0;
      code_sr   = '0;
      if (dur >= thr[REG_SYNC_MIN] && dur <= thr[REG_SYNC_MAX]) begin
        in_frame = 1'b1;
      end else begin
        in_frame = 1'b0;
        emit     = 1'b1;
      end
    end else if (in_frame) begin
      if (!pulse_idx[0]) begin
        if (dur > thr[REG_HIGH_MAX]) begin
          ok = 1'b0;
        end else begin
          high_ok   = 1'b1;
          pulse_idx = pulse_idx + 1'b1;
        end
      end else begin
        // The zero window is tested first, so it wins where the windows overlap.
        bitv = 1'b0;
        if (!high_ok) ok = 1'b0;
        else if (dur >= thr[REG_ZERO_LOW_MIN] && dur <= thr[REG_ZERO_LOW_MAX]) bitv = 1'b0;
        else if (dur >= thr[REG_ONE_LOW_MIN]) bitv = 1'b1;
        else ok = 1'b0;
        if (ok) begin
          code_sr   = {code_sr[CodeBits-2:0], bitv};
          high_ok   = 1'b0;
          pulse_idx = pulse_idx + 1'b1;
          if (pulse_idx == IdxBits'(PulseCount)) begin
            in_frame  = 1'b0;
            pulse_idx = '0;
            emit      = 1'b1;
            mag = int'(code_sr[14:8]) * 10 + int'(code_sr[3:0]);
            t   = code_sr[15] ? -mag : mag;
            r.sensor_id = code_sr[23:16];
            r.raw_code  = code_sr;
            if (code_sr[23:16] == SyncId) begin
              r.status = ST_SYNC;
            end else begin
              r.temp_tenths = TempBits'(t);
              r.battery_ok  = (code_sr[7:4] == BattGoodNib);
              if (last_temp_seen && t == last_temp) begin
                r.status = ST_REPEAT;
              end else begin
                r.status       = ST_NEW;
                last_temp      = t;
                last_temp_seen = 1'b1;
              end
            end
          end
        end
      end
      if (!ok) begin
        in_frame  = 1'b0;
        pulse_idx = '0;
        high_ok   = 1'b0;
        emit      = 1'b1;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Biased toward both ends of a range; an empty range gives any duration.
  function automatic int pick_in(input int lo, input int hi);
    int r;
    if (lo > hi) return $urandom_range(DurMax, 0);
    r = $urandom_range(3, 0);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int pick_outside(input int lo, input int hi);
    if (lo > 0 && (hi >= DurMax || $urandom_range(1, 0) == 1)) return pick_in(0, lo - 1);
    if (hi < DurMax) return pick_in(hi + 1, DurMax);
    return $urandom_range(DurMax, 0);
  endfunction

  function automatic int one_low();
    int lo;
    lo = thr[REG_ONE_LOW_MIN];
    if (thr[REG_ZERO_LOW_MIN] <= thr[REG_ZERO_LOW_MAX] && lo >= thr[REG_ZERO_LOW_MIN] &&
        lo <= thr[REG_ZERO_LOW_MAX])
      lo = thr[REG_ZERO_LOW_MAX] + 1;
    return pick_in(lo, DurMax);
  endfunction

  function automatic int bad_low();
    int zmin, zmax, omin;
    zmin = thr[REG_ZERO_LOW_MIN];
    zmax = thr[REG_ZERO_LOW_MAX];
    omin = thr[REG_ONE_LOW_MIN];
    if (omin > zmax + 1 && $urandom_range(1, 0) == 1) return pick_in(zmax + 1, omin - 1);
    if (zmin > 0 && omin > 0) return pick_in(0, ((zmin < omin) ? zmin : omin) - 1);
    return $urandom_range(DurMax, 0);
  endfunction

  // Random code, often shaped into a sync id, extreme temperatures, plus or minus
  // zero, a good battery or the same temperature as the last new reading.
  function automatic logic [CodeBits-1:0] make_code();
    logic [CodeBits-1:0] c;
    int r, mag, ipart, tpart;
    c = CodeBits'($urandom());
    r = $urandom_range(11, 0);
    if (r != 0 && c[23:16] == SyncId) c[23] = 1'b0;
    case (r)
      0: c[23:16] = SyncId;
      1: begin
        c[14:8] = '1;
        c[3:0]  = '1;
      end
      2: begin
        c[14:8] = '0;
        c[3:0]  = '0;
      end
      3: c[7:4] = BattGoodNib;
      4, 5, 6: begin
        if (last_temp_seen) begin
          mag   = (last_temp < 0) ? -last_temp : last_temp;
          ipart = mag / 10;
          tpart = mag % 10;
          if (ipart > 127) begin
            ipart = 127;
            tpart = mag - 1270;
          end else if (ipart > 0 && tpart < 6 && $urandom_range(1, 0) == 1) begin
            ipart = ipart - 1;
            tpart = tpart + 10;
          end
          c[14:8] = 7'(ipart);
          c[3:0]  = 4'(tpart);
          if (last_temp < 0) c[15] = 1'b1;
          else if (last_temp > 0) c[15] = 1'b0;
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Every stimulus task starts and ends just after a falling edge.
  task automatic send_word(input int dur, input bit start);
    int gap;
    bit emit;
    bit counts;
    reading_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.duration    <= DurBits'(dur);
    in_ch.frame_start <= start;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    counts = start || in_frame;
    decode_pulse(DurBits'(dur), start, emit, r);
    if (counts) fed_words++;
    if (emit) pending_readings.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [CodeBits-1:0] code, input flaw_t flaw);
    int p, d;
    p = $urandom_range(PulseCount - 1, 0);
    if (flaw == FLAW_HIGH) p = p & ~1;
    if (flaw == FLAW_LOW) p = p | 1;
    if (flaw == FLAW_SYNC) send_word(pick_outside(thr[REG_SYNC_MIN], thr[REG_SYNC_MAX]), 1'b1);
    else send_word(pick_in(thr[REG_SYNC_MIN], thr[REG_SYNC_MAX]), 1'b1);
    for (int k = 0; k < PulseCount; k++) begin
      if (flaw == FLAW_CUT && k == p) return;
      if (k % 2 == 0) d = pick_in(0, thr[REG_HIGH_MAX]);
      else if (code[CodeBits - 1 - k / 2]) d = one_low();
      else d = pick_in(thr[REG_ZERO_LOW_MIN], thr[REG_ZERO_LOW_MAX]);
      if (k == p && flaw == FLAW_HIGH) d = pick_outside(0, thr[REG_HIGH_MAX]);
      if (k == p && flaw == FLAW_LOW) d = bad_low();
      send_word(d, 1'b0);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Each access ends by dropping both strobes before it returns, so back-to-back accesses never drive
  // the strobes twice at the same edge.
  task automatic cfg_access(input bit wr, input int idx, input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CfgAddrW'(idx * 4);
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    logic [CfgDataW-1:0] rd;
    for (int i = 0; i < NumRegs; i++) begin
      cfg_access(1'b0, i, '0, rd);
      if (rd !== CfgDataW'(thr[i]))
        report($sformatf("register %0d reads %0h, expected %0h", i, rd, thr[i]));
    end
  endtask

  task automatic cfg_set(input cfg_idx_t idx, input logic [DurBits-1:0] v);
    logic [CfgDataW-1:0] junk, rd;
    junk = $urandom();
    // Bits above the 16-bit threshold carry junk and must be dropped.
    cfg_access(1'b1, int'(idx), {junk[CfgDataW-1:DurBits], v}, rd);
    thr[idx] = v;
  endtask

  task automatic apply_setting(input setting_t s);
    logic [DurBits-1:0] v [NumRegs];
    logic [DurBits-1:0] swap;
    int lo;
    case (s)
      SET_WIDE: begin
        // Every sync fits, no high is too long and the zero window covers everything.
        v[REG_SYNC_MIN] = '0;       v[REG_SYNC_MAX] = '1;
        v[REG_HIGH_MAX] = '1;       v[REG_ZERO_LOW_MIN] = '0;
        v[REG_ZERO_LOW_MAX] = '1;   v[REG_ONE_LOW_MIN] = '0;
      end
      SET_TIGHT: begin
        v[REG_SYNC_MIN] = '1;       v[REG_SYNC_MAX] = '1;
        v[REG_HIGH_MAX] = '0;       v[REG_ZERO_LOW_MIN] = '0;
        v[REG_ZERO_LOW_MAX] = '0;   v[REG_ONE_LOW_MIN] = 16'd1;
      end
      SET_ORDERED: begin
        lo = $urandom_range(60000, 0);
        v[REG_SYNC_MIN] = DurBits'(lo);
        v[REG_SYNC_MAX] = DurBits'(lo + $urandom_range(5000, 0));
        v[REG_HIGH_MAX] = DurBits'($urandom_range(20000, 100));
        lo = $urandom_range(20000, 0);
        v[REG_ZERO_LOW_MIN] = DurBits'(lo);
        lo = lo + $urandom_range(20000, 0);
        v[REG_ZERO_LOW_MAX] = DurBits'(lo);
        v[REG_ONE_LOW_MIN]  = DurBits'(lo + $urandom_range(3000, 1));
      end
      SET_ANY: begin
        for (int i = 0; i < NumRegs; i++) v[i] = DurBits'($urandom());
        if (v[REG_SYNC_MIN] > v[REG_SYNC_MAX]) begin
          swap = v[REG_SYNC_MIN];
          v[REG_SYNC_MIN] = v[REG_SYNC_MAX];
          v[REG_SYNC_MAX] = swap;
        end
        if (v[REG_ZERO_LOW_MIN] > v[REG_ZERO_LOW_MAX]) begin
          swap = v[REG_ZERO_LOW_MIN];
          v[REG_ZERO_LOW_MIN] = v[REG_ZERO_LOW_MAX];
          v[REG_ZERO_LOW_MAX] = swap;
        end
      end
      default: begin
        v[REG_SYNC_MIN] = SyncMinRst;         v[REG_SYNC_MAX] = SyncMaxRst;
        v[REG_HIGH_MAX] = HighMaxRst;         v[REG_ZERO_LOW_MIN] = ZeroLowMinRst;
        v[REG_ZERO_LOW_MAX] = ZeroLowMaxRst;  v[REG_ONE_LOW_MIN] = OneLowMinRst;
      end
    endcase
    for (int i = 0; i < NumRegs; i++) cfg_set(cfg_idx_t'(i), v[i]);
    check_registers();
  endtask

  task automatic test_register_reset();
    check_registers();
  endtask

  task automatic test_sync_window();
    send_word(thr[REG_SYNC_MIN] - 1, 1'b1);
    send_word(thr[REG_SYNC_MAX] + 1, 1'b1);
    send_word(0, 1'b1);
    send_word(DurMax, 1'b1);
    // Pulses while idle are dropped without a result.
    send_word(0, 1'b0);
    send_word(DurMax, 1'b0);
    send_word(thr[REG_SYNC_MIN], 1'b1);
    send_word(500, 1'b0);
    // A new sync inside an open frame silently restarts it.
    send_word(thr[REG_SYNC_MAX], 1'b1);
    drain();
  endtask

  task automatic test_bad_pulses();
    send_word(thr[REG_HIGH_MAX], 1'b0);
    send_word(thr[REG_ZERO_LOW_MIN], 1'b0);
    send_word(0, 1'b0);
    send_word(thr[REG_ZERO_LOW_MAX], 1'b0);
    send_word(0, 1'b0);
    send_word(thr[REG_ONE_LOW_MIN], 1'b0);
    send_word(0, 1'b0);
    send_word(DurMax, 1'b0);
    send_word(thr[REG_HIGH_MAX] + 1, 1'b0);
    send_word(500, 1'b0);
    send_word(thr[REG_SYNC_MIN], 1'b1);
    send_word(0, 1'b0);
    send_word(thr[REG_ZERO_LOW_MAX] + 1, 1'b0);
    send_word(thr[REG_SYNC_MIN], 1'b1);
    send_word(0, 1'b0);
    send_word(thr[REG_ZERO_LOW_MIN] - 1, 1'b0);
    send_word(thr[REG_SYNC_MAX], 1'b1);
    send_word(0, 1'b0);
    send_word(0, 1'b0);
    drain();
  endtask

  task automatic test_unmapped_registers();
    logic [CfgDataW-1:0] rd;
    cfg_access(1'b1, NumRegs, '1, rd);
    cfg_access(1'b1, NumRegs + 1, '0, rd);
    check_registers();
  endtask

  task automatic test_output_backpressure();
    calm     = 1'b1;
    hold_off = 300;
    repeat (30) send_word(pick_outside(thr[REG_SYNC_MIN], thr[REG_SYNC_MAX]), 1'b1);
    send_frame(make_code(), FLAW_NONE);
    calm = 1'b0;
    drain();
  endtask

  task automatic test_frames_under(input setting_t s, input int words);
    int stop_at;
    int r;
    flaw_t f;
    apply_setting(s);
    stop_at = fed_words + words;
    while (fed_words < stop_at) begin
      calm = ($urandom_range(4, 0) == 0);
      if ($urandom_range(5, 0) == 0)
        repeat ($urandom_range(3, 1)) send_word($urandom_range(DurMax, 0), 1'b0);
      r = $urandom_range(15, 0);
      case (r)
        0: f = FLAW_HIGH;
        1: f = FLAW_LOW;
        2: f = FLAW_CUT;
        3: f = FLAW_SYNC;
        default: f = FLAW_NONE;
      endcase
      send_frame(make_code(), f);
    end
    calm = 1'b0;
    drain();
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(4, 0) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        report($sformatf("result word with no reading pending, status %0d", out_ch.status));
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.status !== want.status)
          report($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.sensor_id !== want.sensor_id)
          report($sformatf("sensor_id %0h, expected %0h", out_ch.sensor_id, want.sensor_id));
        if (out_ch.temp_tenths !== want.temp_tenths)
          report($sformatf("temp_tenths %0d, expected %0d", out_ch.temp_tenths,
                           want.temp_tenths));
        if (out_ch.battery_ok !== want.battery_ok)
          report($sformatf("battery_ok %0b, expected %0b", out_ch.battery_ok,
                           want.battery_ok));
        if (out_ch.raw_code !== want.raw_code)
          report($sformatf("raw_code %0h, expected %0h", out_ch.raw_code, want.raw_code));
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.duration    = '0;
    in_ch.frame_start = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    mismatches        = 0;
    fed_words         = 0;
    hold_off          = 0;
    calm              = 1'b0;
    thr[REG_SYNC_MIN]     = SyncMinRst;
    thr[REG_SYNC_MAX]     = SyncMaxRst;
    thr[REG_HIGH_MAX]     = HighMaxRst;
    thr[REG_ZERO_LOW_MIN] = ZeroLowMinRst;
    thr[REG_ZERO_LOW_MAX] = ZeroLowMaxRst;
    thr[REG_ONE_LOW_MIN]  = OneLowMinRst;
    pulse_idx      = '0;
    in_frame       = 1'b0;
    high_ok        = 1'b0;
    code_sr        = '0;
    last_temp      = 0;
    last_temp_seen = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_sync_window();
    test_bad_pulses();
    test_unmapped_registers();
    test_output_backpressure();
    test_frames_under(SET_WIDE, 340);
    test_frames_under(SET_TIGHT, 340);
    test_frames_under(SET_ORDERED, 340);
    test_frames_under(SET_ANY, 340);
    test_frames_under(SET_RESET, 340);

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
